// ===== design/aarm_pkg.sv =====
package aarm_pkg;

    typedef struct packed {
        logic signed [31:0] axis_x;
        logic signed [31:0] axis_y;
        logic signed [31:0] axis_z;
        logic signed [31:0] angle;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
        logic               axis_zero;
    } out_item_t;

    localparam int CORDIC_STEPS = 30;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
    localparam logic signed [34:0] TWO_PI_Q30  = 35'sd6746518852;

    function automatic logic [31:0] atan_entry(input int idx);
        logic [31:0] tbl [0:29];
        tbl[0]  = 32'd843314857; tbl[1]  = 32'd497837829; tbl[2]  = 32'd263043837;
        tbl[3]  = 32'd133525159; tbl[4]  = 32'd67021687;  tbl[5]  = 32'd33543516;
        tbl[6]  = 32'd16775851;  tbl[7]  = 32'd8388437;   tbl[8]  = 32'd4194283;
        tbl[9]  = 32'd2097149;   tbl[10] = 32'd1048576;   tbl[11] = 32'd524288;
        tbl[12] = 32'd262144;    tbl[13] = 32'd131072;    tbl[14] = 32'd65536;
        tbl[15] = 32'd32768;     tbl[16] = 32'd16384;     tbl[17] = 32'd8192;
        tbl[18] = 32'd4096;      tbl[19] = 32'd2048;      tbl[20] = 32'd1024;
        tbl[21] = 32'd512;       tbl[22] = 32'd256;       tbl[23] = 32'd128;
        tbl[24] = 32'd64;        tbl[25] = 32'd32;        tbl[26] = 32'd16;
        tbl[27] = 32'd8;         tbl[28] = 32'd4;         tbl[29] = 32'd2;
        return tbl[idx];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647)
            return 32'sh7fffffff;
        if (v < -36'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

endpackage

// ===== design/axis_angle_rotation_matrix.sv =====
// Rodrigues rotation matrix from an axis and an angle, fully pipelined: one item is taken
// every cycle while the output is not stalled. Its depth is set by the 32-step bit-serial
// square root of the axis length and the 64-step restoring divider chains that normalize
// each component, each one stage a step; the 30-step CORDIC runs beside them.
// A stall on the output freezes the whole pipeline; an item is held in the output register.
module axis_angle_rotation_matrix
    import aarm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 64;

    logic en;
    assign en = !(out_valid && out_stall);
    assign in_stall = !en;

    // stage A: magnitudes, squares
    logic        a_v_reg;
    logic [31:0] a_mag_reg [0:2];
    logic [2:0]  a_neg_reg;
    logic [63:0] a_sq_reg [0:2];
    logic signed [34:0] a_th_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else if (en)
            a_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        logic signed [31:0] comp [0:2];
        logic [31:0] m;
        comp[0] = in_data.axis_x;
        comp[1] = in_data.axis_y;
        comp[2] = in_data.axis_z;
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m = comp[i][31] ? 32'(-comp[i]) : comp[i];
                a_mag_reg[i] <= m;
                a_neg_reg[i] <= comp[i][31];
                a_sq_reg[i]  <= 64'(m) * 64'(m);
            end
            a_th_reg <= {{1{in_data.angle[31]}}, in_data.angle, 2'b00};
        end
    end

    // stage B: sum, coarse angle wrap
    logic        b_v_reg;
    logic [31:0] b_mag_reg [0:2];
    logic [2:0]  b_neg_reg;
    logic [63:0] b_sum_reg;
    logic signed [34:0] b_th_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v_reg <= 1'b0;
        else if (en)
            b_v_reg <= a_v_reg;
    end

    always_ff @(posedge clk)
    begin
        logic signed [34:0] t;
        if (en)
        begin
            b_mag_reg <= a_mag_reg;
            b_neg_reg <= a_neg_reg;
            b_sum_reg <= a_sq_reg[0] + a_sq_reg[1] + a_sq_reg[2];
            t = a_th_reg;
            if (t > PI_Q30)
                t = t - TWO_PI_Q30;
            else if (t < -PI_Q30)
                t = t + TWO_PI_Q30;
            b_th_reg <= t;
        end
    end

    // stage C: normalize shift count k (s * 4^k >= 2^62), fold angle into +-pi/2
    logic        c_v_reg;
    logic [31:0] c_mag_reg [0:2];
    logic [2:0]  c_neg_reg;
    logic [63:0] c_norm_reg;
    logic [4:0]  c_k_reg;
    logic        c_zero_reg;
    logic signed [34:0] c_th_reg;
    logic        c_flip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v_reg <= 1'b0;
        else if (en)
            c_v_reg <= b_v_reg;
    end

    always_ff @(posedge clk)
    begin
        logic [4:0] k;
        k = 5'd0;
        for (int j = 31; j >= 0; j--)
        begin
            if (b_sum_reg[63 - 2*j] || b_sum_reg[62 - 2*j])
                k = 5'(j);
        end
        if (en)
        begin
            c_mag_reg  <= b_mag_reg;
            c_neg_reg  <= b_neg_reg;
            c_k_reg    <= k;
            c_norm_reg <= b_sum_reg << (2 * k);
            c_zero_reg <= (b_sum_reg == '0);
            if (b_th_reg > HALF_PI_Q30)
            begin
                c_th_reg   <= b_th_reg - PI_Q30;
                c_flip_reg <= 1'b1;
            end
            else if (b_th_reg < -HALF_PI_Q30)
            begin
                c_th_reg   <= b_th_reg + PI_Q30;
                c_flip_reg <= 1'b1;
            end
            else
            begin
                c_th_reg   <= b_th_reg;
                c_flip_reg <= 1'b0;
            end
        end
    end

    // square root, one result bit per stage
    logic [63:0] sq_rem_reg [0:SQ_STEPS];
    logic [63:0] sq_res_reg [0:SQ_STEPS];
    logic [104:0] sq_side_reg [0:SQ_STEPS];
    logic [SQ_STEPS:0] sq_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_v_reg <= '0;
        else if (en)
        begin
            sq_v_reg[0] <= c_v_reg;
            for (int i = 1; i <= SQ_STEPS; i++)
                sq_v_reg[i] <= sq_v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [63:0] bitv;
        if (en)
        begin
            sq_rem_reg[0]  <= c_norm_reg;
            sq_res_reg[0]  <= '0;
            sq_side_reg[0] <= {c_mag_reg[0], c_mag_reg[1], c_mag_reg[2],
                               c_k_reg, c_neg_reg, c_zero_reg};
            for (int i = 0; i < SQ_STEPS; i++)
            begin
                bitv = 64'd1 << (62 - 2*i);
                if (sq_rem_reg[i] >= sq_res_reg[i] + bitv)
                begin
                    sq_rem_reg[i+1] <= sq_rem_reg[i] - (sq_res_reg[i] + bitv);
                    sq_res_reg[i+1] <= (sq_res_reg[i] >> 1) + bitv;
                end
                else
                begin
                    sq_rem_reg[i+1] <= sq_rem_reg[i];
                    sq_res_reg[i+1] <= sq_res_reg[i] >> 1;
                end
                sq_side_reg[i+1] <= sq_side_reg[i];
            end
        end
    end

    logic [31:0] root;
    logic [104:0] side;
    assign root = sq_res_reg[SQ_STEPS][31:0];
    assign side = sq_side_reg[SQ_STEPS];

    // restoring dividers (numerator mag << (k+30), 93 bits max), one quotient bit per stage
    localparam int NW = 94;
    logic [NW-1:0] dv_num_reg [0:2][0:DIV_STEPS];
    logic [32:0]   dv_rem_reg [0:2][0:DIV_STEPS];
    logic [31:0]   dv_d_reg   [0:DIV_STEPS];
    logic [3:0]    dv_side_reg [0:DIV_STEPS];
    logic [DIV_STEPS:0] dv_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_v_reg <= '0;
        else if (en)
        begin
            dv_v_reg[0] <= sq_v_reg[SQ_STEPS];
            for (int i = 1; i <= DIV_STEPS; i++)
                dv_v_reg[i] <= dv_v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        logic [32:0] r;
        logic [31:0] mg;
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                mg = side[104 - 32*c -: 32];
                dv_num_reg[c][0] <= NW'({mg, 30'd0}) << side[8:4];
                dv_rem_reg[c][0] <= '0;
            end
            dv_d_reg[0]    <= (root == '0) ? 32'd1 : root;
            dv_side_reg[0] <= side[3:0];
            for (int i = 0; i < DIV_STEPS; i++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    r = {dv_rem_reg[c][i][31:0], dv_num_reg[c][i][63]};
                    if (r >= {1'b0, dv_d_reg[i]})
                    begin
                        dv_rem_reg[c][i+1] <= r - {1'b0, dv_d_reg[i]};
                        dv_num_reg[c][i+1] <= {dv_num_reg[c][i][NW-1:64],
                                               dv_num_reg[c][i][62:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg[c][i+1] <= r;
                        dv_num_reg[c][i+1] <= {dv_num_reg[c][i][NW-1:64],
                                               dv_num_reg[c][i][62:0], 1'b0};
                    end
                end
                dv_d_reg[i+1]    <= dv_d_reg[i];
                dv_side_reg[i+1] <= dv_side_reg[i];
            end
        end
    end

    // unit axis, Q2.30
    logic signed [31:0] u [0:2];
    logic               u_zero;
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic [31:0] qv;
            qv = dv_num_reg[c][DIV_STEPS][31:0];
            if (dv_side_reg[DIV_STEPS][0])
                u[c] = '0;
            else
                u[c] = dv_side_reg[DIV_STEPS][c+1] ? 32'(-qv) : qv;
        end
        u_zero = dv_side_reg[DIV_STEPS][0];
    end

    // cordic, one iteration per stage, runs beside the axis path
    logic signed [33:0] cx_reg [0:CORDIC_STEPS];
    logic signed [33:0] cy_reg [0:CORDIC_STEPS];
    logic signed [34:0] cz_reg [0:CORDIC_STEPS];
    logic [CORDIC_STEPS:0] cf_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0] <= CORDIC_GAIN;
            cy_reg[0] <= '0;
            cz_reg[0] <= c_th_reg;
            cf_reg[0] <= c_flip_reg;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                if (!cz_reg[i][34])
                begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] - 35'(atan_entry(i));
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] + 35'(atan_entry(i));
                end
                cf_reg[i+1] <= cf_reg[i];
            end
        end
    end

    logic [67:0] cs_din;
    logic [67:0] cs_dout;
    logic        cs_v;
    assign cs_din = {cf_reg[CORDIC_STEPS] ? -cx_reg[CORDIC_STEPS] : cx_reg[CORDIC_STEPS],
                     cf_reg[CORDIC_STEPS] ? -cy_reg[CORDIC_STEPS] : cy_reg[CORDIC_STEPS]};

    aarm_pipe #(
        .WIDTH(68),
        .DEPTH(SQ_STEPS + 1 + DIV_STEPS - CORDIC_STEPS)
    ) u_cs_delay (
        .clk  (clk),
        .rst_n(rst_n),
        .en   (en),
        .vin  (1'b0),
        .din  (cs_din),
        .vout (cs_v),
        .dout (cs_dout)
    );

    // stage P: products u*u and u*s
    logic        p_v_reg;
    logic signed [33:0] p_c_reg, p_q_reg;
    logic signed [32:0] p_pp_reg [0:5];
    logic signed [32:0] p_w_reg  [0:2];
    logic        p_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_v_reg <= 1'b0;
        else if (en)
            p_v_reg <= dv_v_reg[DIV_STEPS] | cs_v;
    end

    always_ff @(posedge clk)
    begin
        logic signed [33:0] cc, ss;
        cc = cs_dout[67:34];
        ss = cs_dout[33:0];
        if (en)
        begin
            p_c_reg    <= cc;
            p_q_reg    <= 34'sd1073741824 - cc;
            p_zero_reg <= u_zero;
            p_pp_reg[0] <= 33'((64'(u[0]) * 64'(u[0])) >>> 30);
            p_pp_reg[1] <= 33'((64'(u[0]) * 64'(u[1])) >>> 30);
            p_pp_reg[2] <= 33'((64'(u[0]) * 64'(u[2])) >>> 30);
            p_pp_reg[3] <= 33'((64'(u[1]) * 64'(u[1])) >>> 30);
            p_pp_reg[4] <= 33'((64'(u[1]) * 64'(u[2])) >>> 30);
            p_pp_reg[5] <= 33'((64'(u[2]) * 64'(u[2])) >>> 30);
            for (int c = 0; c < 3; c++)
                p_w_reg[c] <= 33'((66'(u[c]) * 66'(ss)) >>> 30);
        end
    end

    // stage T: times q
    logic        t_v_reg;
    logic signed [33:0] t_c_reg;
    logic signed [33:0] t_t_reg [0:5];
    logic signed [32:0] t_w_reg [0:2];
    logic        t_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            t_v_reg <= 1'b0;
        else if (en)
            t_v_reg <= p_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_c_reg    <= p_c_reg;
            t_w_reg    <= p_w_reg;
            t_zero_reg <= p_zero_reg;
            for (int i = 0; i < 6; i++)
                t_t_reg[i] <= 34'((68'(p_pp_reg[i]) * 68'(p_q_reg)) >>> 30);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= t_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data.m00 <= sat32(36'(t_c_reg) + 36'(t_t_reg[0]));
            out_data.m01 <= sat32(36'(t_t_reg[1]) - 36'(t_w_reg[2]));
            out_data.m02 <= sat32(36'(t_t_reg[2]) + 36'(t_w_reg[1]));
            out_data.m10 <= sat32(36'(t_t_reg[1]) + 36'(t_w_reg[2]));
            out_data.m11 <= sat32(36'(t_c_reg) + 36'(t_t_reg[3]));
            out_data.m12 <= sat32(36'(t_t_reg[4]) - 36'(t_w_reg[0]));
            out_data.m20 <= sat32(36'(t_t_reg[2]) - 36'(t_w_reg[1]));
            out_data.m21 <= sat32(36'(t_t_reg[4]) + 36'(t_w_reg[0]));
            out_data.m22 <= sat32(36'(t_c_reg) + 36'(t_t_reg[5]));
            out_data.axis_zero <= t_zero_reg;
        end
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output item changed under stall");
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall mismatch");
    a_zero_diag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.axis_zero |-> out_data.m01 == 0 && out_data.m12 == 0)
        else $error("zero axis off-diagonal nonzero");

endmodule

// ===== design/aarm_pipe.sv =====
module aarm_pipe
    import aarm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vin,
    input  logic [WIDTH-1:0] din,
    output logic             vout,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] data_reg [0:DEPTH-1];
    logic [DEPTH-1:0] valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg[0] <= vin;
            for (int i = 1; i < DEPTH; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                data_reg[i] <= data_reg[i-1];
            end
        end
    end

    assign vout = valid_reg[DEPTH-1];
    assign dout = data_reg[DEPTH-1];

endmodule
